// File: design/rvid_pkg.sv
// ----------------------------------------------------------------------------
// RV32IM decode package
// Opcode constants, the decoded operation codes, the immediate format bundle
// and the funct3 lookup functions used by the operation decoder.
// ----------------------------------------------------------------------------
package rvid_pkg;

  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;
  localparam logic [6:0] OPC_JAL     = 7'h6F;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_OPIMM   = 7'h13;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_MISCMEM = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM  = 7'h73;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [2:0] F3_SLLI = 3'd1;
  localparam logic [2:0] F3_SRXI = 3'd5;
  localparam logic [2:0] F3_JALR = 3'd0;

  typedef enum logic [5:0] {
    OP_ILLEGAL = 6'd0,
    OP_LUI     = 6'd1,  OP_AUIPC  = 6'd2,  OP_JAL    = 6'd3,  OP_JALR   = 6'd4,
    OP_BEQ     = 6'd5,  OP_BNE    = 6'd6,  OP_BLT    = 6'd7,  OP_BGE    = 6'd8,
    OP_BLTU    = 6'd9,  OP_BGEU   = 6'd10,
    OP_LB      = 6'd11, OP_LH     = 6'd12, OP_LW     = 6'd13, OP_LBU    = 6'd14,
    OP_LHU     = 6'd15,
    OP_SB      = 6'd16, OP_SH     = 6'd17, OP_SW     = 6'd18,
    OP_ADDI    = 6'd19, OP_SLTI   = 6'd20, OP_SLTIU  = 6'd21, OP_XORI   = 6'd22,
    OP_ORI     = 6'd23, OP_ANDI   = 6'd24,
    OP_SLLI    = 6'd25, OP_SRLI   = 6'd26, OP_SRAI   = 6'd27,
    OP_ADD     = 6'd28, OP_SUB    = 6'd29, OP_SLL    = 6'd30, OP_SLT    = 6'd31,
    OP_SLTU    = 6'd32, OP_XOR    = 6'd33, OP_SRL    = 6'd34, OP_SRA    = 6'd35,
    OP_OR      = 6'd36, OP_AND    = 6'd37,
    OP_MUL     = 6'd38, OP_MULH   = 6'd39, OP_MULHSU = 6'd40, OP_MULHU  = 6'd41,
    OP_DIV     = 6'd42, OP_DIVU   = 6'd43, OP_REM    = 6'd44, OP_REMU   = 6'd45,
    OP_FENCE   = 6'd46, OP_ECALL  = 6'd47, OP_EBREAK = 6'd48
  } op_e;

  // Immediates of every format, built side by side from one word.
  typedef struct packed {
    logic [31:0] i_imm;
    logic [31:0] s_imm;
    logic [31:0] b_imm;
    logic [31:0] u_imm;
    logic [31:0] j_imm;
  } imm_fmt_t;

  function automatic op_e branch_op(input logic [2:0] f3);
    op_e r;
    unique case (f3)
      3'd0:    r = OP_BEQ;
      3'd1:    r = OP_BNE;
      3'd4:    r = OP_BLT;
      3'd5:    r = OP_BGE;
      3'd6:    r = OP_BLTU;
      3'd7:    r = OP_BGEU;
      default: r = OP_ILLEGAL;
    endcase
    return r;
  endfunction

  function automatic op_e load_op(input logic [2:0] f3);
    op_e r;
    unique case (f3)
      3'd0:    r = OP_LB;
      3'd1:    r = OP_LH;
      3'd2:    r = OP_LW;
      3'd4:    r = OP_LBU;
      3'd5:    r = OP_LHU;
      default: r = OP_ILLEGAL;
    endcase
    return r;
  endfunction

  function automatic op_e store_op(input logic [2:0] f3);
    op_e r;
    unique case (f3)
      3'd0:    r = OP_SB;
      3'd1:    r = OP_SH;
      3'd2:    r = OP_SW;
      default: r = OP_ILLEGAL;
    endcase
    return r;
  endfunction

  function automatic op_e opimm_op(input logic [2:0] f3);
    op_e r;
    unique case (f3)
      3'd0:    r = OP_ADDI;
      3'd1:    r = OP_SLLI;
      3'd2:    r = OP_SLTI;
      3'd3:    r = OP_SLTIU;
      3'd4:    r = OP_XORI;
      3'd5:    r = OP_SRLI;
      3'd6:    r = OP_ORI;
      default: r = OP_ANDI;
    endcase
    return r;
  endfunction

  function automatic op_e reg_op(input logic [2:0] f3);
    op_e r;
    unique case (f3)
      3'd0:    r = OP_ADD;
      3'd1:    r = OP_SLL;
      3'd2:    r = OP_SLT;
      3'd3:    r = OP_SLTU;
      3'd4:    r = OP_XOR;
      3'd5:    r = OP_SRL;
      3'd6:    r = OP_OR;
      default: r = OP_AND;
    endcase
    return r;
  endfunction

  function automatic op_e reg_alt_op(input logic [2:0] f3);
    op_e r;
    unique case (f3)
      3'd0:    r = OP_SUB;
      3'd5:    r = OP_SRA;
      default: r = OP_ILLEGAL;
    endcase
    return r;
  endfunction

  function automatic op_e muldiv_op(input logic [2:0] f3);
    op_e r;
    unique case (f3)
      3'd0:    r = OP_MUL;
      3'd1:    r = OP_MULH;
      3'd2:    r = OP_MULHSU;
      3'd3:    r = OP_MULHU;
      3'd4:    r = OP_DIV;
      3'd5:    r = OP_DIVU;
      3'd6:    r = OP_REM;
      default: r = OP_REMU;
    endcase
    return r;
  endfunction

endpackage

// File: design/rvid_imm_gen.sv
// ----------------------------------------------------------------------------
// RV32IM immediate generator
// Builds the sign-extended I, S, B, U and J immediates of one word in
// parallel; the decoder picks the one that the opcode calls for.
// ----------------------------------------------------------------------------
module rvid_imm_gen (
  input  logic [31:0]             word_i,
  output rvid_pkg::imm_fmt_t      imm_o
);
  import rvid_pkg::*;

  logic sign;

  assign sign = word_i[31];

  always_comb begin
    imm_o.i_imm = {{20{sign}}, word_i[31:20]};
    imm_o.s_imm = {{20{sign}}, word_i[31:25], word_i[11:7]};
    imm_o.b_imm = {{20{sign}}, word_i[7], word_i[30:25], word_i[11:8], 1'b0};
    imm_o.u_imm = {word_i[31:12], 12'h000};
    imm_o.j_imm = {{12{sign}}, word_i[19:12], word_i[20], word_i[30:21], 1'b0};
  end

endmodule

// File: design/rvid_decode.sv
// ----------------------------------------------------------------------------
// RV32IM operation decoder
// Maps opcode, funct3 and funct7 to the operation code and selects the
// immediate of the matching format. Purely combinational.
// ----------------------------------------------------------------------------
module rvid_decode (
  input  logic [31:0]        word_i,
  input  rvid_pkg::imm_fmt_t imm_i,
  output rvid_pkg::op_e      op_o,
  output logic [31:0]        imm_o
);
  import rvid_pkg::*;

  logic [6:0] opcode;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] shamt;
  op_e        shift_op;

  assign opcode = word_i[6:0];
  assign f3     = word_i[14:12];
  assign f7     = word_i[31:25];
  assign shamt  = word_i[24:20];

  // Shift immediates only allow zero upper bits, or the SRAI pattern.
  always_comb begin
    shift_op = opimm_op(f3);
    if (f3 == F3_SRXI && f7 == F7_ALT) begin
      shift_op = OP_SRAI;
    end else if (f7 != F7_BASE) begin
      shift_op = OP_ILLEGAL;
    end
  end

  always_comb begin
    op_o  = OP_ILLEGAL;
    imm_o = '0;
    unique case (opcode)
      OPC_LUI: begin
        op_o  = OP_LUI;
        imm_o = imm_i.u_imm;
      end
      OPC_AUIPC: begin
        op_o  = OP_AUIPC;
        imm_o = imm_i.u_imm;
      end
      OPC_JAL: begin
        op_o  = OP_JAL;
        imm_o = imm_i.j_imm;
      end
      OPC_JALR: begin
        if (f3 == F3_JALR) begin
          op_o  = OP_JALR;
          imm_o = imm_i.i_imm;
        end
      end
      OPC_BRANCH: begin
        op_o  = branch_op(f3);
        imm_o = imm_i.b_imm;
      end
      OPC_LOAD: begin
        op_o  = load_op(f3);
        imm_o = imm_i.i_imm;
      end
      OPC_STORE: begin
        op_o  = store_op(f3);
        imm_o = imm_i.s_imm;
      end
      OPC_OPIMM: begin
        if (f3 == F3_SLLI || f3 == F3_SRXI) begin
          op_o  = shift_op;
          imm_o = (shift_op != OP_ILLEGAL) ? {27'd0, shamt} : imm_i.i_imm;
        end else begin
          op_o  = opimm_op(f3);
          imm_o = imm_i.i_imm;
        end
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          op_o = reg_op(f3);
        end else if (f7 == F7_ALT) begin
          op_o = reg_alt_op(f3);
        end else if (f7 == F7_MULDIV) begin
          op_o = muldiv_op(f3);
        end
      end
      OPC_MISCMEM: begin
        op_o = OP_FENCE;
      end
      OPC_SYSTEM: begin
        if (word_i == WORD_ECALL) begin
          op_o = OP_ECALL;
        end else if (word_i == WORD_EBREAK) begin
          op_o = OP_EBREAK;
        end
      end
      default: begin
        op_o = OP_ILLEGAL;
      end
    endcase
  end

endmodule

// File: design/rv32im_instruction_decode.sv
// ----------------------------------------------------------------------------
// RV32IM instruction decode stage
// Registers one instruction word, decodes it and registers the operation,
// register fields and immediate; the illegal flag is derived from the operation.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     start while !busy      instr_word_i
//  result    done_o (one cycle)     operation_o, dest_reg_o, src_reg_one_o,
//                                   src_reg_two_o, immediate_o, is_illegal_o
//
// An item is taken every cycle. Its result passes the input register, the decode
// logic and the result register before it is shown on done_o.
// busy is always low since both stages advance every cycle.
// Reset clears the two valid flags only; payload registers are not reset.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module rv32im_instruction_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        instr_word_i,
  output logic               done_o,
  output logic [5:0]         operation_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src_reg_one_o,
  output logic [4:0]         src_reg_two_o,
  output logic signed [31:0] immediate_o,
  output logic               is_illegal_o
);
  import rvid_pkg::*;

  logic        in_vld_q;
  logic [31:0] word_q;
  logic        out_vld_q;
  op_e         op_d, op_q;
  logic [31:0] imm_d, imm_q;
  logic [4:0]  rd_q, rs1_q, rs2_q;
  imm_fmt_t    imm_fmt;
  logic        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= instr_word_i;
    end
    if (in_vld_q) begin
      op_q  <= op_d;
      imm_q <= imm_d;
      rd_q  <= word_q[11:7];
      rs1_q <= word_q[19:15];
      rs2_q <= word_q[24:20];
    end
  end

  rvid_imm_gen u_imm_gen (
    .word_i (word_q),
    .imm_o  (imm_fmt)
  );

  rvid_decode u_decode (
    .word_i (word_q),
    .imm_i  (imm_fmt),
    .op_o   (op_d),
    .imm_o  (imm_d)
  );

  assign done_o        = out_vld_q;
  assign operation_o   = op_q;
  assign dest_reg_o    = rd_q;
  assign src_reg_one_o = rs1_q;
  assign src_reg_two_o = rs2_q;
  assign immediate_o   = signed'(imm_q);
  assign is_illegal_o  = (op_q == OP_ILLEGAL);

  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 2))
    else $error("result strobe without an accepted item two cycles earlier");

  a_fields_match_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (dest_reg_o == $past(instr_word_i[11:7], 2)) &&
               (src_reg_one_o == $past(instr_word_i[19:15], 2)) &&
               (src_reg_two_o == $past(instr_word_i[24:20], 2)))
    else $error("register fields do not match the accepted word");

  a_op_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (operation_o <= 6'(OP_EBREAK)))
    else $error("operation code out of range");

  a_system_imm_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(instr_word_i[6:0], 2) == OPC_SYSTEM) |-> (immediate_o == 32'sd0))
    else $error("system instruction carries a nonzero immediate");

endmodule

// File: verif/rv32im_instruction_decode_tb.sv
// ----------------------------------------------------------------------------
// RV32IM instruction decode testbench
// Drives instruction words through the start/busy handshake and checks every
// done_o result against a decoder written here, field by field and in order.
// A directed set of boundary encodings is followed by random, mostly
// well-formed instructions under several sender idling patterns.
// ----------------------------------------------------------------------------
module rv32im_instruction_decode_tb;
  import rvid_pkg::*;

  typedef struct {
    op_e         operation;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_one;
    logic [4:0]  src_reg_two;
    logic [31:0] immediate;
    logic        is_illegal;
  } decoded_instr_t;

  typedef struct {
    logic [31:0] word;
    int unsigned idle_pct;
    bit          wait_for_drain;
  } pending_word_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start        = 1'b0;
  logic [31:0]        instr_word_i = '0;
  logic               busy;
  logic               done_o;
  logic [5:0]         operation_o;
  logic [4:0]         dest_reg_o;
  logic [4:0]         src_reg_one_o;
  logic [4:0]         src_reg_two_o;
  logic signed [31:0] immediate_o;
  logic               is_illegal_o;

  pending_word_t  pending_words[$];
  decoded_instr_t expected_decodes[$];
  int unsigned    words_sent     = 0;
  int unsigned    results_seen   = 0;
  int unsigned    mismatch_count = 0;

  rv32im_instruction_decode dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .instr_word_i  (instr_word_i),
    .done_o        (done_o),
    .operation_o   (operation_o),
    .dest_reg_o    (dest_reg_o),
    .src_reg_one_o (src_reg_one_o),
    .src_reg_two_o (src_reg_two_o),
    .immediate_o   (immediate_o),
    .is_illegal_o  (is_illegal_o)
  );

  initial forever #2 clk_i = ~clk_i;

  function automatic decoded_instr_t decode_word(input logic [31:0] w);
    decoded_instr_t r;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] i_imm;
    logic [31:0] s_imm;
    logic [31:0] b_imm;
    logic [31:0] u_imm;
    logic [31:0] j_imm;
    f3    = w[14:12];
    f7    = w[31:25];
    i_imm = {{20{w[31]}}, w[31:20]};
    s_imm = {{20{w[31]}}, w[31:25], w[11:7]};
    b_imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
    u_imm = {w[31:12], 12'b0};
    j_imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
    r.operation   = OP_ILLEGAL;
    r.immediate   = '0;
    r.dest_reg    = w[11:7];
    r.src_reg_one = w[19:15];
    r.src_reg_two = w[24:20];
    case (w[6:0])
      OPC_LUI: begin
        r.operation = OP_LUI;
        r.immediate = u_imm;
      end
      OPC_AUIPC: begin
        r.operation = OP_AUIPC;
        r.immediate = u_imm;
      end
      OPC_JAL: begin
        r.operation = OP_JAL;
        r.immediate = j_imm;
      end
      OPC_JALR: begin
        if (f3 == F3_JALR) begin
          r.operation = OP_JALR;
          r.immediate = i_imm;
        end
      end
      OPC_BRANCH: begin
        r.immediate = b_imm;
        case (f3)
          3'd0:    r.operation = OP_BEQ;
          3'd1:    r.operation = OP_BNE;
          3'd4:    r.operation = OP_BLT;
          3'd5:    r.operation = OP_BGE;
          3'd6:    r.operation = OP_BLTU;
          3'd7:    r.operation = OP_BGEU;
          default: r.operation = OP_ILLEGAL;
        endcase
      end
      OPC_LOAD: begin
        r.immediate = i_imm;
        case (f3)
          3'd0:    r.operation = OP_LB;
          3'd1:    r.operation = OP_LH;
          3'd2:    r.operation = OP_LW;
          3'd4:    r.operation = OP_LBU;
          3'd5:    r.operation = OP_LHU;
          default: r.operation = OP_ILLEGAL;
        endcase
      end
      OPC_STORE: begin
        r.immediate = s_imm;
        case (f3)
          3'd0:    r.operation = OP_SB;
          3'd1:    r.operation = OP_SH;
          3'd2:    r.operation = OP_SW;
          default: r.operation = OP_ILLEGAL;
        endcase
      end
      OPC_OPIMM: begin
        r.immediate = i_imm;
        case (f3)
          3'd0: r.operation = OP_ADDI;
          3'd2: r.operation = OP_SLTI;
          3'd3: r.operation = OP_SLTIU;
          3'd4: r.operation = OP_XORI;
          3'd6: r.operation = OP_ORI;
          3'd7: r.operation = OP_ANDI;
          default: begin
            // Shifts: the upper bits select the variant, the immediate is shamt.
            if (f3 == F3_SRXI && f7 == F7_ALT) r.operation = OP_SRAI;
            else if (f7 != F7_BASE)            r.operation = OP_ILLEGAL;
            else if (f3 == F3_SLLI)            r.operation = OP_SLLI;
            else                               r.operation = OP_SRLI;
            if (r.operation != OP_ILLEGAL) r.immediate = {27'b0, w[24:20]};
          end
        endcase
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0:    r.operation = OP_ADD;
            3'd1:    r.operation = OP_SLL;
            3'd2:    r.operation = OP_SLT;
            3'd3:    r.operation = OP_SLTU;
            3'd4:    r.operation = OP_XOR;
            3'd5:    r.operation = OP_SRL;
            3'd6:    r.operation = OP_OR;
            default: r.operation = OP_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          case (f3)
            3'd0:    r.operation = OP_SUB;
            3'd5:    r.operation = OP_SRA;
            default: r.operation = OP_ILLEGAL;
          endcase
        end else if (f7 == F7_MULDIV) begin
          case (f3)
            3'd0:    r.operation = OP_MUL;
            3'd1:    r.operation = OP_MULH;
            3'd2:    r.operation = OP_MULHSU;
            3'd3:    r.operation = OP_MULHU;
            3'd4:    r.operation = OP_DIV;
            3'd5:    r.operation = OP_DIVU;
            3'd6:    r.operation = OP_REM;
            default: r.operation = OP_REMU;
          endcase
        end
      end
      OPC_MISCMEM: r.operation = OP_FENCE;
      OPC_SYSTEM: begin
        if (w == WORD_ECALL)       r.operation = OP_ECALL;
        else if (w == WORD_EBREAK) r.operation = OP_EBREAK;
      end
      default: r.operation = OP_ILLEGAL;
    endcase
    r.is_illegal = (r.operation == OP_ILLEGAL);
    return r;
  endfunction

  // Mostly well-formed encodings with random content, plus a share of noise.
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(99) >= 8) begin
      case ($urandom_range(10))
        0: w[6:0] = OPC_LUI;
        1: w[6:0] = OPC_AUIPC;
        2: w[6:0] = OPC_JAL;
        3: begin
          w[6:0] = OPC_JALR;
          if ($urandom_range(3) != 0) w[14:12] = F3_JALR;
        end
        4: w[6:0] = OPC_BRANCH;
        5: w[6:0] = OPC_LOAD;
        6: w[6:0] = OPC_STORE;
        7: begin
          w[6:0] = OPC_OPIMM;
          if (w[13:12] == 2'b01 && $urandom_range(4) != 0)
            w[31:25] = (w[14] && $urandom_range(1) == 1) ? F7_ALT : F7_BASE;
        end
        8: begin
          w[6:0] = OPC_OP;
          if ($urandom_range(5) != 0) begin
            case ($urandom_range(2))
              0:       w[31:25] = F7_BASE;
              1:       w[31:25] = F7_ALT;
              default: w[31:25] = F7_MULDIV;
            endcase
          end
        end
        9: w[6:0] = OPC_MISCMEM;
        default: begin
          case ($urandom_range(3))
            0:       w = WORD_ECALL;
            1:       w = WORD_EBREAK;
            default: w[6:0] = OPC_SYSTEM;
          endcase
        end
      endcase
    end
    return w;
  endfunction

  task automatic queue_word(input logic [31:0] w, input int unsigned idle_pct,
                            input bit wait_for_drain);
    pending_word_t p;
    p.word           = w;
    p.idle_pct       = idle_pct;
    p.wait_for_drain = wait_for_drain;
    pending_words.push_back(p);
  endtask

  task automatic check_field(input string name, input logic [31:0] expected_val,
                             input logic [31:0] actual_val);
    if (actual_val !== expected_val) begin
      $error("%s mismatch: expected %h, got %h", name, expected_val, actual_val);
      mismatch_count++;
    end
  endtask

  // Sender. The counters are updated with nonblocking assignments, so the
  // drain test below sees the values from before the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start        <= 1'b0;
      instr_word_i <= '0;
    end else if (!start || !busy) begin
      if (start) words_sent <= words_sent + 1;
      if (pending_words.size() != 0 &&
          (!pending_words[0].wait_for_drain ||
           (!start && words_sent == results_seen)) &&
          $urandom_range(99) >= pending_words[0].idle_pct) begin
        start        <= 1'b1;
        instr_word_i <= pending_words[0].word;
        void'(pending_words.pop_front());
      end else begin
        start        <= 1'b0;
        instr_word_i <= $urandom();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) expected_decodes.push_back(decode_word(instr_word_i));
      if (done_o) begin
        results_seen <= results_seen + 1;
        if (expected_decodes.size() == 0) begin
          $error("unexpected result: operation %0d, immediate %h",
                 operation_o, immediate_o);
          mismatch_count++;
        end else begin
          decoded_instr_t e;
          e = expected_decodes.pop_front();
          check_field("operation", 32'(e.operation), 32'(operation_o));
          check_field("dest_reg", 32'(e.dest_reg), 32'(dest_reg_o));
          check_field("src_reg_one", 32'(e.src_reg_one), 32'(src_reg_one_o));
          check_field("src_reg_two", 32'(e.src_reg_two), 32'(src_reg_two_o));
          check_field("immediate", e.immediate, immediate_o);
          check_field("is_illegal", 32'(e.is_illegal), 32'(is_illegal_o));
        end
      end
    end
  end

  initial begin
    int unsigned phase_idle[4];
    phase_idle = '{0, 55, 0, 16};

    // Boundary encodings and the illegal corners.
    queue_word(32'h0000_0000, 0, 1'b0);
    queue_word(32'hFFFF_FFFF, 0, 1'b0);
    queue_word(WORD_ECALL, 0, 1'b0);
    queue_word(WORD_EBREAK, 0, 1'b0);
    queue_word(32'h3412_1073, 0, 1'b0);  // CSR access
    queue_word(32'h0020_0073, 0, 1'b0);  // other SYSTEM word
    queue_word(32'hFFFF_F0B7, 0, 1'b0);  // LUI
    queue_word(32'h0000_0017, 0, 1'b0);  // AUIPC
    queue_word(32'h8000_006F, 0, 1'b0);  // JAL, most negative offset
    queue_word(32'hFFFF_FFEF, 0, 1'b0);  // JAL, all ones
    queue_word(32'hFFF0_8067, 0, 1'b0);  // JALR
    queue_word(32'h0000_1067, 0, 1'b0);  // JALR with nonzero funct3
    queue_word(32'hFFFF_A0E3, 0, 1'b0);  // branch with unused funct3
    queue_word(32'hFFFF_FFE3, 0, 1'b0);  // BGEU, all ones
    queue_word(32'h8000_3003, 0, 1'b0);  // load with unused funct3
    queue_word(32'hFE00_4023, 0, 1'b0);  // store with unused funct3
    queue_word(32'hFFFF_2FA3, 0, 1'b0);  // SW, all-ones offset
    queue_word(32'h41F0_5013, 0, 1'b0);  // SRAI by 31
    queue_word(32'h0200_5013, 0, 1'b0);  // shift right with bad upper bits
    queue_word(32'h4000_1013, 0, 1'b0);  // SLLI with the arithmetic bit set
    queue_word(32'h01F0_1013, 0, 1'b0);  // SLLI by 31
    queue_word(32'h8000_0013, 0, 1'b0);  // ADDI, most negative
    queue_word(32'h4000_0033, 0, 1'b0);  // SUB
    queue_word(32'h4000_1033, 0, 1'b0);  // alternate funct7 on SLL
    queue_word(32'h0400_0033, 0, 1'b0);  // unused funct7
    queue_word(32'h0200_7033, 0, 1'b0);  // REMU
    queue_word(32'hFFFF_FF8F, 0, 1'b0);  // FENCE with every other bit set

    // Random phases; the idling ones keep short bursts without gaps.
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 262; i++) begin
        queue_word(random_instruction(), (i % 50 < 10) ? 0 : phase_idle[p],
                   p != 0 && i == 0);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_words.size() != 0 || start || expected_decodes.size() != 0);
    repeat (8) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("rv32im_instruction_decode_tb: done, clean");
    end else begin
      $display("rv32im_instruction_decode_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("rv32im_instruction_decode_tb: done, errors");
    $finish;
  end

endmodule
